@@ hdl/dqpt_pkg.sv @@
`default_nettype none

package dqpt_pkg;

  localparam int CMD_W    = 3;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 7;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PAL_CHECK  = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_PUSH_FULL = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] rear_value;
    logic [CNT_W-1:0]        count;
    logic                    is_empty;
    logic                    is_palindrome;
  } dqpt_result_t;

endpackage

`default_nettype wire

@@ hdl/dqpt_ifs.sv @@
`default_nettype none

interface dqpt_in_if;
  import dqpt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

interface dqpt_out_if;
  import dqpt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [VAL_W-1:0] front_value;
  logic signed [VAL_W-1:0] rear_value;
  logic [CNT_W-1:0]        count;
  logic                    is_empty;
  logic                    is_palindrome;

  modport source (
    output valid, output status, output front_value, output rear_value,
    output count, output is_empty, output is_palindrome, input ready
  );
  modport sink (
    input valid, input status, input front_value, input rear_value,
    input count, input is_empty, input is_palindrome, output ready
  );
endinterface

`default_nettype wire

@@ hdl/deque_with_palindrome_trim.sv @@
`default_nettype none

// Bounded double-ended queue of DEPTH signed words with a destructive
// palindrome trim. Each input word carries a command (push front, push back,
// pop front, pop back, clear, palindrome check) and a value; every command
// yields exactly one result word describing the queue afterwards, with -1 in
// the front and rear fields when the queue is empty. Words live in a ring in
// a memory with one write port and two registered read ports, driven by a
// small sequencer around two ring adders and a comparator. A push, pop, clear
// or unused command passes the execute, wait and response states before the
// next word can be accepted, as each update is written and then read back
// through the registered read ports. A palindrome check runs execute, wait
// and trim, going back to wait for each matching outer pair it removes, as
// each pair is read and compared once per pass. The result sits in an output
// register, so the next input word can be accepted while a result waits.
module deque_with_palindrome_trim #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dqpt_in_if.sink     in_chan,
  dqpt_out_if.source  out_chan
);
  import dqpt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [WORD_WIDTH-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

  logic                  res_valid, res_ready;
  dqpt_result_t          res;

  logic                  out_valid_r, out_valid_nxt;
  dqpt_result_t          out_res_r, out_res_nxt;

  dqpt_seq #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_cmd      (in_chan.cmd),
    .in_value    (in_chan.value),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b)
  );

  dqpt_ram #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH),
    .AW         (AW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  // The output register takes a new result when empty or being drained.
  assign res_ready = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_res_r.status;
  assign out_chan.front_value   = out_res_r.front_value;
  assign out_chan.rear_value    = out_res_r.rear_value;
  assign out_chan.count         = out_res_r.count;
  assign out_chan.is_empty      = out_res_r.is_empty;
  assign out_chan.is_palindrome = out_res_r.is_palindrome;

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> out_valid_r && $stable(out_res_r))
    else $error("pending result word was overwritten");

  a_result_loaded : assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> out_valid_r)
    else $error("handed result word was not registered");

  a_empty_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.is_empty == (out_res_r.count == '0) || DEPTH > 127))
    else $error("empty flag disagrees with count");

endmodule

`default_nettype wire

@@ hdl/dqpt_ram.sv @@
`default_nettype none

module dqpt_ram #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32,
  parameter int AW         = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WORD_WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]         raddr_a,
  input  wire logic [AW-1:0]         raddr_b,
  output logic      [WORD_WIDTH-1:0] rdata_a,
  output logic      [WORD_WIDTH-1:0] rdata_b
);

  logic [WORD_WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

`default_nettype wire

@@ hdl/dqpt_seq.sv @@
`default_nettype none

module dqpt_seq #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32,
  parameter int AW         = $clog2(DEPTH),
  parameter int CW         = $clog2(DEPTH + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [dqpt_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic signed [dqpt_pkg::VAL_W-1:0] in_value,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output dqpt_pkg::dqpt_result_t              res,
  output logic                                mem_we,
  output logic      [AW-1:0]                  mem_waddr,
  output logic      [WORD_WIDTH-1:0]          mem_wdata,
  output logic      [AW-1:0]                  mem_raddr_a,
  output logic      [AW-1:0]                  mem_raddr_b,
  input  wire logic [WORD_WIDTH-1:0]          mem_rdata_a,
  input  wire logic [WORD_WIDTH-1:0]          mem_rdata_b
);
  import dqpt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_TRIM,
    S_RESP
  } state_t;

  state_t                state_r, state_nxt;
  logic [CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [WORD_WIDTH-1:0] val_r, val_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic                  pal_r, pal_nxt;

  logic                  full, empty, two_or_more, ends_match, trim_go;
  logic [AW-1:0]         head_inc, head_dec, rear_addr, tail_addr;
  logic signed [WORD_WIDTH-1:0] front_w, rear_w;

  // Ring addition; both operands are below DEPTH, so one subtract folds the sum.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign full        = (count_r == CW'(DEPTH));
  assign empty       = (count_r == '0);
  assign two_or_more = (count_r > CW'(1));
  assign head_inc    = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign head_dec    = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign rear_addr   = ring_add(head_r, AW'(count_r - CW'(1)));
  assign tail_addr   = ring_add(head_r, AW'(count_r));

  assign mem_raddr_a = head_r;
  assign mem_raddr_b = rear_addr;
  assign mem_wdata   = val_r;

  assign ends_match  = (mem_rdata_a == mem_rdata_b);
  assign trim_go     = (state_r == S_TRIM) && two_or_more && ends_match;

  assign front_w = mem_rdata_a;
  assign rear_w  = mem_rdata_b;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);

  always_comb begin
    res.status        = status_r;
    res.front_value   = empty ? '1 : VAL_W'(front_w);
    res.rear_value    = empty ? '1 : VAL_W'(rear_w);
    res.count         = CNT_W'(count_r);
    res.is_empty      = empty;
    res.is_palindrome = pal_r;
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    pal_nxt    = pal_r;
    mem_we     = 1'b0;
    mem_waddr  = head_dec;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_cmd;
          val_nxt    = WORD_WIDTH'(in_value);
          status_nxt = STAT_OK;
          pal_nxt    = 1'b0;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_WAIT;
        case (cmd_r)
          CMD_PUSH_FRONT: begin
            if (full) begin
              status_nxt = STAT_PUSH_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = head_dec;
              head_nxt  = head_dec;
              count_nxt = count_r + CW'(1);
            end
          end
          CMD_PUSH_BACK: begin
            if (full) begin
              status_nxt = STAT_PUSH_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = tail_addr;
              count_nxt = count_r + CW'(1);
            end
          end
          CMD_POP_FRONT: begin
            if (empty) begin
              status_nxt = STAT_POP_EMPTY;
            end else begin
              head_nxt  = head_inc;
              count_nxt = count_r - CW'(1);
            end
          end
          CMD_POP_BACK: begin
            if (empty) begin
              status_nxt = STAT_POP_EMPTY;
            end else begin
              count_nxt = count_r - CW'(1);
            end
          end
          CMD_CLEAR: begin
            head_nxt  = '0;
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_WAIT: begin
        // The read ports now see the updated head and rear positions.
        state_nxt = (cmd_r == CMD_PAL_CHECK) ? S_TRIM : S_RESP;
      end
      S_TRIM: begin
        if (trim_go) begin
          head_nxt  = head_inc;
          count_nxt = count_r - CW'(2);
          state_nxt = S_WAIT;
        end else begin
          pal_nxt   = !two_or_more;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      status_r <= STAT_OK;
      pal_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
      pal_r    <= pal_nxt;
    end
    cmd_r <= cmd_nxt;
    val_r <= val_nxt;
  end

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("stored count exceeds depth");

  a_head_bound : assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= AW'(DEPTH - 1))
    else $error("head index outside the ring");

  a_trim_pair : assert property (@(posedge clk) disable iff (!rst_n)
    trim_go |=> (count_r == $past(count_r) - CW'(2)) && (state_r == S_WAIT))
    else $error("trim did not remove a pair");

  a_full_push_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && full &&
     (cmd_r == CMD_PUSH_FRONT || cmd_r == CMD_PUSH_BACK))
    |=> $stable(count_r) && $stable(head_r) && status_r == STAT_PUSH_FULL)
    else $error("push on full changed the queue");

endmodule

`default_nettype wire

@@ verif/deque_with_palindrome_trim_tb.sv @@
module deque_with_palindrome_trim_tb;
  import dqpt_pkg::*;

  localparam int DEPTH        = 64;
  localparam int TOTAL_WORDS  = 1150;
  localparam int LONG_HOLD    = 160;
  localparam int TAIL_CYCLES  = 80;
  localparam int CYCLE_LIMIT  = 600000;

  // Command codes the block does not define; they must leave the queue alone.
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  dqpt_in_if  in_if ();
  dqpt_out_if out_if ();

  deque_with_palindrome_trim dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic signed [VAL_W-1:0] shadow_words[$];
  dqpt_result_t            pending_results[$];
  int unsigned             error_count = 0;
  int unsigned             words_sent = 0;
  int unsigned             burst_left = 0;
  int unsigned             cycle_count = 0;
  bit                      hold_request = 1'b0;

  // Applies one command to the shadow deque and returns the result word it
  // should produce.
  function automatic dqpt_result_t apply_command(input logic [CMD_W-1:0] op,
                                                 input logic signed [VAL_W-1:0] v);
    dqpt_result_t r;
    int unsigned  n;
    r = '0;
    r.status = STAT_OK;
    case (op)
      CMD_PUSH_FRONT: begin
        if (shadow_words.size() >= DEPTH) r.status = STAT_PUSH_FULL;
        else shadow_words.push_front(v);
      end
      CMD_PUSH_BACK: begin
        if (shadow_words.size() >= DEPTH) r.status = STAT_PUSH_FULL;
        else shadow_words.push_back(v);
      end
      CMD_POP_FRONT: begin
        if (shadow_words.size() == 0) r.status = STAT_POP_EMPTY;
        else void'(shadow_words.pop_front());
      end
      CMD_POP_BACK: begin
        if (shadow_words.size() == 0) r.status = STAT_POP_EMPTY;
        else void'(shadow_words.pop_back());
      end
      CMD_CLEAR: begin
        shadow_words.delete();
      end
      CMD_PAL_CHECK: begin
        // Matching outer pairs are removed for good, even when a later pair
        // turns out to differ.
        r.is_palindrome = 1'b1;
        while (shadow_words.size() >= 2 && r.is_palindrome) begin
          if (shadow_words[0] != shadow_words[shadow_words.size()-1]) begin
            r.is_palindrome = 1'b0;
          end else begin
            void'(shadow_words.pop_front());
            void'(shadow_words.pop_back());
          end
        end
      end
      default: ;
    endcase
    n = shadow_words.size();
    if (n == 0) begin
      r.front_value = -1;
      r.rear_value  = -1;
    end else begin
      r.front_value = shadow_words[0];
      r.rear_value  = shadow_words[n-1];
    end
    r.count    = n[CNT_W-1:0];
    r.is_empty = (n == 0);
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 3);
      1: v = -$signed(VAL_W'($urandom_range(1, 3)));
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Offers one word and waits for its handshake. The sender works in bursts;
  // within this task valid is only lowered in the idle stretch between bursts.
  task automatic send_word(input logic [CMD_W-1:0] op, input logic signed [VAL_W-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_if.cmd   <= op;
    in_if.value <= v;
    in_if.valid <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(apply_command(op, v));
    words_sent++;
  endtask

  // Stops offering until every outstanding result has been taken.
  task automatic pause_until_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    burst_left = 0;
  endtask

  task automatic send_random_command(input int unsigned push_share);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_share)
      send_word($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
    else if (r < 92)
      send_word($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, pick_value());
    else if (r < 96)
      send_word(CMD_PAL_CHECK, pick_value());
    else if (r < 98)
      send_word(CMD_CLEAR, pick_value());
    else
      send_word($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B, pick_value());
  endtask

  // Builds a symmetric run around the current contents, sometimes with one
  // word flipped so the trim stops partway, then asks for the verdict.
  task automatic send_palindrome_run();
    int unsigned             pairs;
    int unsigned             bad_pair;
    logic signed [VAL_W-1:0] w;
    logic signed [VAL_W-1:0] w_back;
    if ($urandom_range(0, 2) != 0) send_word(CMD_CLEAR, pick_value());
    pairs = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 32) : $urandom_range(0, 8);
    bad_pair = ($urandom_range(0, 2) == 0) ? $urandom_range(0, pairs) : pairs + 1;
    if ($urandom_range(0, 1)) send_word(CMD_PUSH_BACK, pick_value());
    for (int unsigned i = 0; i < pairs; i++) begin
      w = pick_value();
      w_back = (i == bad_pair) ? (w ^ (32'sd1 <<< $urandom_range(0, VAL_W-1))) : w;
      send_word(CMD_PUSH_FRONT, w);
      send_word(CMD_PUSH_BACK, w_back);
    end
    send_word(CMD_PAL_CHECK, pick_value());
  endtask

  task automatic test_edge_cases();
    send_word(CMD_POP_FRONT, '0);
    send_word(CMD_POP_BACK, '1);
    send_word(CMD_PAL_CHECK, '0);
    send_word(CMD_SPARE_A, 32'sh7FFF_FFFF);
    send_word(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_word(CMD_PAL_CHECK, '0);
    send_word(CMD_PUSH_BACK, 32'sh8000_0000);
    send_word(CMD_PAL_CHECK, '0);
    send_word(CMD_POP_FRONT, '0);
    send_word(CMD_POP_BACK, '0);
    send_word(CMD_PUSH_BACK, '1);
    send_word(CMD_PUSH_FRONT, '0);
    send_word(CMD_CLEAR, '1);
    // An even run that matches all the way down empties the queue.
    send_word(CMD_PUSH_BACK, 32'sd5);
    send_word(CMD_PUSH_BACK, 32'sh8000_0000);
    send_word(CMD_PUSH_BACK, 32'sh8000_0000);
    send_word(CMD_PUSH_BACK, 32'sd5);
    send_word(CMD_PAL_CHECK, '0);
    send_word(CMD_PUSH_FRONT, 32'sd3);
    send_word(CMD_PUSH_FRONT, 32'sd9);
    send_word(CMD_PUSH_BACK, 32'sd9);
    send_word(CMD_PAL_CHECK, '0);
    send_word(CMD_PUSH_FRONT, 32'sd1);
    send_word(CMD_PUSH_BACK, 32'sd2);
    send_word(CMD_PAL_CHECK, '0);
    send_word(CMD_SPARE_B, '1);
  endtask

  task automatic test_full_ring();
    logic signed [VAL_W-1:0] w;
    send_word(CMD_CLEAR, '0);
    for (int i = 0; i < DEPTH / 2; i++) begin
      w = pick_value();
      send_word(CMD_PUSH_FRONT, w);
      send_word(CMD_PUSH_BACK, w);
    end
    send_word(CMD_PUSH_FRONT, pick_value());
    send_word(CMD_PUSH_BACK, pick_value());
    // A full even palindrome: the longest trim the block can do.
    send_word(CMD_PAL_CHECK, '0);
    for (int i = 0; i < DEPTH; i++)
      send_word(($urandom_range(0, 1)) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
    send_word(CMD_PUSH_BACK, pick_value());
    send_word(CMD_PUSH_FRONT, pick_value());
    for (int i = 0; i < DEPTH + 2; i++)
      send_word(($urandom_range(0, 1)) ? CMD_POP_FRONT : CMD_POP_BACK, pick_value());
  endtask

  task automatic test_output_backpressure();
    pause_until_drained();
    hold_request = 1'b1;
    burst_left = 60;
    for (int i = 0; i < 50; i++) send_random_command(60);
    pause_until_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned run_len;
    int unsigned push_share;
    while (words_sent < TOTAL_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_palindrome_run();
        8: pause_until_drained();
        default: begin
          run_len = $urandom_range(5, 30);
          case ($urandom_range(0, 2))
            0: push_share = 25;
            1: push_share = 50;
            default: push_share = 80;
          endcase
          for (int unsigned i = 0; i < run_len; i++) send_random_command(push_share);
        end
      endcase
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.cmd    <= CMD_CLEAR;
    in_if.value  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_cases();
    test_full_ring();
    test_output_backpressure();
    test_random_traffic();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("deque_with_palindrome_trim regression: pass");
    end else begin
      $display("deque_with_palindrome_trim regression: fail");
    end
    $finish;
  end

  // The receiver switches between always ready, random stalls, a fixed
  // on/off pattern and heavy stalling; a long hold-off can be requested.
  initial begin
    int unsigned seg_left;
    int unsigned stall_mode;
    int unsigned hold_left;
    int unsigned tick;
    seg_left = 0;
    stall_mode = 0;
    hold_left = 0;
    tick = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (seg_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        seg_left = $urandom_range(20, 160);
      end
      seg_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= (tick % 7) < 3;
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic void check_field(input string fname, input logic [VAL_W-1:0] want,
                                      input logic [VAL_W-1:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin
    dqpt_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result word with none expected, expected none, actual count %0d",
                 $time, out_if.count);
      end else begin
        want = pending_results.pop_front();
        check_field("status", VAL_W'(want.status), VAL_W'(out_if.status));
        check_field("front_value", want.front_value, out_if.front_value);
        check_field("rear_value", want.rear_value, out_if.rear_value);
        check_field("count", VAL_W'(want.count), VAL_W'(out_if.count));
        check_field("is_empty", VAL_W'(want.is_empty), VAL_W'(out_if.is_empty));
        check_field("is_palindrome", VAL_W'(want.is_palindrome),
                    VAL_W'(out_if.is_palindrome));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("deque_with_palindrome_trim regression: fail");
      $finish;
    end
  end

endmodule

@@ sim.f @@
hdl/dqpt_pkg.sv
hdl/dqpt_ifs.sv
hdl/dqpt_ram.sv
hdl/dqpt_seq.sv
hdl/deque_with_palindrome_trim.sv
verif/deque_with_palindrome_trim_tb.sv
